>>> hdl/dh_forward_kinematics_chain_top_defines.svh
// ---------------------------------------------------------------------------
// dh forward kinematics chain assertion macros
// shared concurrent assertion forms for the chain rtl
// ---------------------------------------------------------------------------
`ifndef DH_FORWARD_KINEMATICS_CHAIN_TOP_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define DHFK_ASSERT_HOLDS(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define DHFK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dhfk_pkg.sv
// ---------------------------------------------------------------------------
// dhfk package
// types, constants and functions shared by the kinematics chain rtl
// ---------------------------------------------------------------------------
`default_nettype none

package dhfk_pkg;

    // cordic iteration count, capped at thirty
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_MAX     = 30;
    localparam int CORDIC_ITERS   = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
    localparam int CNT_W          = $clog2(CORDIC_ITERS + 1);

    // cordic datapath width, q30 with headroom
    localparam int CW = 36;

    localparam logic signed [CW-1:0] Q30_ONE     = 36'sd1073741824;
    localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_START  = 36'sd652032874;

    // multiplier and accumulator widths
    localparam int MA_W   = 32;
    localparam int MB_W   = 33;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_W  = ACC_W - 30;

    typedef struct packed {
        logic signed [15:0] joint_angle;
        logic signed [15:0] twist_angle;
        logic signed [31:0] link_length;
        logic signed [31:0] link_offset;
        logic               start_chain;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rot_00;
        logic signed [31:0] rot_01;
        logic signed [31:0] rot_02;
        logic signed [31:0] rot_10;
        logic signed [31:0] rot_11;
        logic signed [31:0] rot_12;
        logic signed [31:0] rot_20;
        logic signed [31:0] rot_21;
        logic signed [31:0] rot_22;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_out_item;

    // travels with each product through the multiply-accumulate pipe
    typedef struct packed {
        logic       build;
        logic [3:0] dst;
        logic       first;
        logic       last;
    } t_mac_tag;

    // atan(2^-i) in q30, exact power of two from i = 10 on
    function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
        logic signed [CW-1:0] v;
        unique case (i)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            default: v = 36'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/dhfk_if.sv
// ---------------------------------------------------------------------------
// dhfk channel interfaces
// valid/ready channels for joint items and pose results
// ---------------------------------------------------------------------------
`default_nettype none

interface dhfk_in_if;
    logic               valid;
    logic               ready;
    dhfk_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dhfk_out_if;
    logic                valid;
    logic                ready;
    dhfk_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/dhfk_cordic.sv
// ---------------------------------------------------------------------------
// dhfk cordic
// iterative rotation-mode cordic, q3.13 angle in, q30 sine and cosine out
// ---------------------------------------------------------------------------
`default_nettype none

module dhfk_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_angle,
    output logic                    o_done,
    output logic signed [31:0]      o_sin,
    output logic signed [31:0]      o_cos
);
    import dhfk_pkg::*;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_RED  = 3'd1;
    localparam logic [2:0] C_FOLD = 3'd2;
    localparam logic [2:0] C_RUN  = 3'd3;
    localparam logic [2:0] C_FIN  = 3'd4;

    logic [2:0]           r_state;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic                 r_flip;
    logic [CNT_W-1:0]     r_i;
    logic                 r_done;
    logic signed [31:0]   r_sin, r_cos;

    logic [4:0]           w_sh;
    logic signed [CW-1:0] w_dx, w_dy, w_at, w_xf, w_yf, w_xc, w_yc;

    assign w_sh = 5'(r_i);
    assign w_dx = r_y >>> w_sh;
    assign w_dy = r_x >>> w_sh;
    assign w_at = atan_entry(w_sh);
    assign w_xf = r_flip ? -r_x : r_x;
    assign w_yf = r_flip ? -r_y : r_y;

    always_comb begin
        if (w_xf > Q30_ONE) w_xc = Q30_ONE;
        else if (w_xf < -Q30_ONE) w_xc = -Q30_ONE;
        else w_xc = w_xf;
        if (w_yf > Q30_ONE) w_yc = Q30_ONE;
        else if (w_yf < -Q30_ONE) w_yc = -Q30_ONE;
        else w_yc = w_yf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_z     <= CW'(i_angle) <<< 17;
                        r_x     <= GAIN_START;
                        r_y     <= '0;
                        r_flip  <= 1'b0;
                        r_state <= C_RED;
                    end
                end
                C_RED: begin
                    if (r_z > Q30_PI) r_z <= r_z - Q30_TWO_PI;
                    else if (r_z < -Q30_PI) r_z <= r_z + Q30_TWO_PI;
                    r_state <= C_FOLD;
                end
                C_FOLD: begin
                    // fold into the right half plane, negate at the end
                    if (r_z > Q30_HALF_PI) begin
                        r_z    <= r_z - Q30_PI;
                        r_flip <= 1'b1;
                    end else if (r_z < -Q30_HALF_PI) begin
                        r_z    <= r_z + Q30_PI;
                        r_flip <= 1'b1;
                    end
                    r_i     <= '0;
                    r_state <= C_RUN;
                end
                C_RUN: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == CNT_W'(CORDIC_ITERS - 1)) r_state <= C_FIN;
                end
                C_FIN: begin
                    r_cos   <= 32'(w_xc);
                    r_sin   <= 32'(w_yc);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

`default_nettype wire

>>> hdl/dhfk_mac.sv
// ---------------------------------------------------------------------------
// dhfk mac
// pipelined multiply-accumulate with q30 round half up on the sum
// ---------------------------------------------------------------------------
`default_nettype none

module dhfk_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic signed [dhfk_pkg::MA_W-1:0] i_a,
    input  wire logic signed [dhfk_pkg::MB_W-1:0] i_b,
    input  dhfk_pkg::t_mac_tag                    i_tag,
    output logic                                  o_valid,
    output dhfk_pkg::t_mac_tag                    o_tag,
    output logic signed [dhfk_pkg::RND_W-1:0]     o_value
);
    import dhfk_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_mac_tag                 r_ptag, r_atag;
    logic                     r_pv, r_av;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_base, w_rnd;

    assign w_base = r_ptag.first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_av <= 1'b0;
        end else begin
            r_pv <= i_valid;
            r_av <= r_pv && r_ptag.last;
        end
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        r_ptag <= i_tag;
        if (r_pv) begin
            r_acc  <= w_base + ACC_W'(r_prod);
            r_atag <= r_ptag;
        end
    end

    assign w_rnd   = (r_acc + (ACC_W'(1) <<< 29)) >>> 30;
    assign o_valid = r_av;
    assign o_tag   = r_atag;
    assign o_value = RND_W'(w_rnd);

endmodule

`default_nettype wire

>>> hdl/dh_forward_kinematics_chain_top.sv
// ---------------------------------------------------------------------------
// dh forward kinematics chain top
// modified denavit-hartenberg joint transform, accumulated into a pose
// ---------------------------------------------------------------------------
// Each joint transfer (theta, alpha, a, d, start flag) is right-multiplied
// into the kept pose and the new pose (q2.30 rotation, saturated q16.16
// translation) comes out as one result transfer. A single iterative cordic
// runs theta then alpha, then one shared 32x33 multiplier pipe does the six
// transform products and the 36 pose products, one per cycle. The input is
// ready only when the sequencer is idle; a finished pose waits in an output
// register, so the next joint is taken while it is unread.
`default_nettype none
`include "dh_forward_kinematics_chain_top_defines.svh"

module dh_forward_kinematics_chain_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dhfk_in_if.sink    i_in,
    dhfk_out_if.source o_out
);
    import dhfk_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CT     = 3'd1;
    localparam logic [2:0] S_CA     = 3'd2;
    localparam logic [2:0] S_BUILD  = 3'd3;
    localparam logic [2:0] S_BDRAIN = 3'd4;
    localparam logic [2:0] S_MAT    = 3'd5;
    localparam logic [2:0] S_MDRAIN = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] r_state, n_state;
    t_in_item   r_item;

    // pose and the new pose being built
    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_nrot [9];
    logic signed [31:0] r_npos [3];

    // joint transform
    logic signed [31:0]     r_tr [9];
    logic signed [MB_W-1:0] r_tp [3];
    logic signed [31:0]     r_st, r_ct, r_sa, r_ca;

    // issue counters
    logic [3:0] r_dst;
    logic [1:0] r_n;

    t_out_item r_out;
    logic      r_ovalid;

    logic                   w_accept, w_load;
    logic                   w_cstart, w_cdone;
    logic signed [15:0]     w_cangle;
    logic signed [31:0]     w_sin, w_cos;
    logic                   w_mvalid, w_rvalid;
    logic signed [MA_W-1:0] w_ma;
    logic signed [MB_W-1:0] w_mb;
    t_mac_tag               w_mtag, w_rtag;
    logic signed [RND_W-1:0] w_rval;
    logic [1:0]             w_row, w_col, w_rrow, w_rcol;
    logic [3:0]             w_aidx, w_bidx;
    logic signed [RND_W:0]  w_psum;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    // theta runs first, alpha is started as soon as theta is done
    assign w_cstart = w_accept || ((r_state == S_CT) && w_cdone);
    assign w_cangle = (r_state == S_CT) ? r_item.twist_angle : i_in.data.joint_angle;

    dhfk_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (w_cangle),
        .o_done  (w_cdone),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // operand selection for the shared multiplier
    assign w_row  = r_dst[3:2];
    assign w_col  = r_dst[1:0];
    assign w_aidx = 4'(w_row) * 4'd3 + 4'(r_n);
    assign w_bidx = (w_col == 2'd3) ? 4'd0 : 4'(r_n) * 4'd3 + 4'(w_col);

    always_comb begin
        w_mvalid = (r_state == S_BUILD) || (r_state == S_MAT);
        w_mtag.build = (r_state == S_BUILD);
        w_mtag.dst   = r_dst;
        w_mtag.first = (r_state == S_BUILD) || (r_n == 2'd0);
        w_mtag.last  = (r_state == S_BUILD) || (r_n == 2'd2);
        if (r_state == S_BUILD) begin
            // st*ca, ct*ca, st*sa, ct*sa, -sa*d, ca*d
            unique case (r_dst)
                4'd0:    begin w_ma = r_st;  w_mb = MB_W'(r_ca); end
                4'd1:    begin w_ma = r_ct;  w_mb = MB_W'(r_ca); end
                4'd2:    begin w_ma = r_st;  w_mb = MB_W'(r_sa); end
                4'd3:    begin w_ma = r_ct;  w_mb = MB_W'(r_sa); end
                4'd4:    begin w_ma = -r_sa; w_mb = MB_W'(r_item.link_offset); end
                default: begin w_ma = r_ca;  w_mb = MB_W'(r_item.link_offset); end
            endcase
        end else begin
            w_ma = r_rot[w_aidx];
            w_mb = (w_col == 2'd3) ? r_tp[r_n] : MB_W'(r_tr[w_bidx]);
        end
    end

    dhfk_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mvalid),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_tag   (w_mtag),
        .o_valid (w_rvalid),
        .o_tag   (w_rtag),
        .o_value (w_rval)
    );

    assign w_rrow = w_rtag.dst[3:2];
    assign w_rcol = w_rtag.dst[1:0];
    assign w_psum = (RND_W+1)'(w_rval) + (RND_W+1)'(r_pos[w_rrow]);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_CT;
            S_CT:     if (w_cdone) n_state = S_CA;
            S_CA:     if (w_cdone) n_state = S_BUILD;
            S_BUILD:  if (r_dst == 4'd5) n_state = S_BDRAIN;
            S_BDRAIN: if (w_rvalid && w_rtag.build && w_rtag.dst == 4'd5) n_state = S_MAT;
            S_MAT:    if (r_dst == 4'd11 && r_n == 2'd2) n_state = S_MDRAIN;
            S_MDRAIN: if (w_rvalid && !w_rtag.build && w_rtag.dst == 4'd11) n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dst    <= '0;
            r_n      <= '0;
            for (int k = 0; k < 9; k++) r_rot[k] <= (k % 4 == 0) ? 32'sd1073741824 : 32'sd0;
            for (int k = 0; k < 3; k++) r_pos[k] <= '0;
        end else begin
            r_state <= n_state;

            if (w_load) r_ovalid <= 1'b1;
            else if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;

            if (w_accept) begin
                r_item <= i_in.data;
                // start of a chain: identity pose before this joint
                if (i_in.data.start_chain) begin
                    for (int k = 0; k < 9; k++)
                        r_rot[k] <= (k % 4 == 0) ? 32'sd1073741824 : 32'sd0;
                    for (int k = 0; k < 3; k++) r_pos[k] <= '0;
                end
            end

            if (r_state == S_CT && w_cdone) begin
                r_st <= w_sin;
                r_ct <= w_cos;
            end

            if (r_state == S_CA && w_cdone) begin
                r_sa    <= w_sin;
                r_ca    <= w_cos;
                r_tr[0] <= r_ct;
                r_tr[1] <= -r_st;
                r_tr[2] <= '0;
                r_tr[5] <= -w_sin;
                r_tr[8] <= w_cos;
                r_tp[0] <= MB_W'(r_item.link_length);
                r_dst   <= '0;
                r_n     <= '0;
            end

            if (r_state == S_BUILD) begin
                r_dst <= (r_dst == 4'd5) ? 4'd0 : r_dst + 4'd1;
            end

            if (r_state == S_MAT) begin
                if (r_n == 2'd2) begin
                    r_n   <= '0;
                    // skip nothing: dst runs 0..11 as row*4 + column
                    r_dst <= r_dst + 4'd1;
                end else begin
                    r_n <= r_n + 2'd1;
                end
            end

            // results from the multiply-accumulate pipe
            if (w_rvalid) begin
                if (w_rtag.build) begin
                    unique case (w_rtag.dst)
                        4'd0:    r_tr[3] <= 32'(w_rval);
                        4'd1:    r_tr[4] <= 32'(w_rval);
                        4'd2:    r_tr[6] <= 32'(w_rval);
                        4'd3:    r_tr[7] <= 32'(w_rval);
                        4'd4:    r_tp[1] <= MB_W'(w_rval);
                        default: r_tp[2] <= MB_W'(w_rval);
                    endcase
                end else if (w_rcol == 2'd3) begin
                    // translation saturates at the 32-bit range
                    if (w_psum > (RND_W+1)'(64'sd2147483647))
                        r_npos[w_rrow] <= 32'sh7fffffff;
                    else if (w_psum < -(RND_W+1)'(64'sd2147483648))
                        r_npos[w_rrow] <= 32'sh80000000;
                    else
                        r_npos[w_rrow] <= 32'(w_psum);
                end else begin
                    if (w_rval > RND_W'(64'sd1073741824))
                        r_nrot[4'(w_rrow) * 4'd3 + 4'(w_rcol)] <= 32'sd1073741824;
                    else if (w_rval < -RND_W'(64'sd1073741824))
                        r_nrot[4'(w_rrow) * 4'd3 + 4'(w_rcol)] <= -32'sd1073741824;
                    else
                        r_nrot[4'(w_rrow) * 4'd3 + 4'(w_rcol)] <= 32'(w_rval);
                end
            end

            if (w_load) begin
                for (int k = 0; k < 9; k++) r_rot[k] <= r_nrot[k];
                for (int k = 0; k < 3; k++) r_pos[k] <= r_npos[k];
            end
        end
    end

    // result register, loaded once the previous pose has been taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.rot_00 <= r_nrot[0];
            r_out.rot_01 <= r_nrot[1];
            r_out.rot_02 <= r_nrot[2];
            r_out.rot_10 <= r_nrot[3];
            r_out.rot_11 <= r_nrot[4];
            r_out.rot_12 <= r_nrot[5];
            r_out.rot_20 <= r_nrot[6];
            r_out.rot_21 <= r_nrot[7];
            r_out.rot_22 <= r_nrot[8];
            r_out.pos_x  <= r_npos[0];
            r_out.pos_y  <= r_npos[1];
            r_out.pos_z  <= r_npos[2];
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // mac results only arrive while the transform or pose is being built
    `DHFK_ASSERT_HOLDS(a_result_window, i_clk, i_rst_n, w_rvalid,
        (r_state == S_BUILD) || (r_state == S_BDRAIN) || (r_state == S_MAT) ||
        (r_state == S_MDRAIN), "mac result outside a build phase")
    // an accepted joint starts the theta cordic run
    `DHFK_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept,
        (r_state == S_CT) && !i_in.ready, "accepted joint did not start cordic")
    // finishing a pose leaves a valid result and an idle sequencer
    `DHFK_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, w_load,
        r_ovalid && (r_state == S_IDLE), "finished pose not presented")

endmodule

`default_nettype wire
